/* hdl/hrt_pkg.sv */
// Shared types and constants for the heap region tracker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package hrt_pkg;

  localparam int ADDR_W        = 48;
  localparam int SIZE_W        = 32;
  localparam int ID_W          = 16;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   ident;
    logic [SIZE_W-1:0] len;
    logic [ADDR_W-1:0] base;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic              rd_vld;
    logic [ADDR_W-1:0] addr;
  } scan_req_t;

  typedef struct packed {
    logic              match_hit;
    logic [ID_W-1:0]   match_ident;
    logic [SIZE_W-1:0] match_len;
    logic              free_hit;
    logic              best_hit;
    logic [ADDR_W-1:0] best_base;
    logic [SIZE_W-1:0] best_len;
    logic [ID_W-1:0]   best_ident;
    logic [ADDR_W:0]   best_end;
  } scan_res_t;

endpackage
`default_nettype wire

/* hdl/hrt_if.sv */
// Valid/ready channel interfaces for requests and responses of the tracker.
// Depends on hrt_pkg for the field widths.
`default_nettype none
interface hrt_req_if;
  import hrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [SIZE_W-1:0] size;
  logic [ID_W-1:0]   obj_id;

  modport source (output valid, op, addr, size, obj_id, input ready);
  modport sink (input valid, op, addr, size, obj_id, output ready);
endinterface

interface hrt_rsp_if;
  import hrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   found_id;
  logic [ADDR_W-1:0] found_base;
  logic [SIZE_W-1:0] found_size;
  logic              overrun;

  modport source (output valid, status, found_id, found_base, found_size, overrun,
                  input ready);
  modport sink (input valid, status, found_id, found_base, found_size, overrun,
                output ready);
endinterface
`default_nettype wire

/* hdl/hrt_scan.sv */
// Accumulates exact-base match, first free slot and best lower base while the
// table streams past one entry per cycle. Depends on hrt_pkg.
`default_nettype none
module hrt_scan import hrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire scan_req_t                      req,
  input  wire entry_t                         rd_data,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
  output scan_res_t                           res,
  output logic      [$clog2(TABLE_DEPTH)-1:0] match_idx,
  output logic      [$clog2(TABLE_DEPTH)-1:0] free_idx
);

  logic is_match;
  logic is_free;
  logic is_better;

  assign is_match  = rd_data.valid && (rd_data.base == req.addr) && !res.match_hit;
  assign is_free   = !rd_data.valid && !res.free_hit;
  assign is_better = rd_data.valid && (rd_data.base <= req.addr) &&
                     (!res.best_hit || (rd_data.base > res.best_base));

  always_ff @(posedge clk) begin
    if (rst || req.start) begin
      res.match_hit <= 1'b0;
      res.free_hit  <= 1'b0;
      res.best_hit  <= 1'b0;
    end else if (req.rd_vld) begin
      if (is_match) begin
        res.match_hit   <= 1'b1;
        match_idx       <= rd_idx;
        res.match_ident <= rd_data.ident;
        res.match_len   <= rd_data.len;
      end
      if (is_free) begin
        res.free_hit <= 1'b1;
        free_idx     <= rd_idx;
      end
      if (is_better) begin
        res.best_hit   <= 1'b1;
        res.best_base  <= rd_data.base;
        res.best_len   <= rd_data.len;
        res.best_ident <= rd_data.ident;
        res.best_end   <= {1'b0, rd_data.base} + {{(ADDR_W-SIZE_W+1){1'b0}}, rd_data.len};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/heap_region_tracker.sv */
// Heap region tracker: one request in, one response out, table of N regions.
// A request transaction starts one pass over all N entries (N = TABLE_DEPTH)
// through the single read port of the region memory, then S_DRAIN and
// S_FINISH register the response; no new request is taken before that. The
// response register lets the next request start while a response waits.
// After reset a clearing pass empties all N entries before a request is taken.
`default_nettype none
module heap_region_tracker import hrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  hrt_req_if.sink   req,
  hrt_rsp_if.source rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IW-1:0] idx;
  logic [IW-1:0] rd_idx;
  logic          rd_vld;
  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_data;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic [SIZE_W-1:0] size;
  logic [ID_W-1:0]   obj_id;
  logic [ADDR_W:0]   acc_end;

  scan_req_t     scan_req;
  scan_res_t     scan_res;
  logic [IW-1:0] match_idx;
  logic [IW-1:0] free_idx;

  logic              out_valid;
  status_t           out_status;
  logic [ID_W-1:0]   out_id;
  logic [ADDR_W-1:0] out_base;
  logic [SIZE_W-1:0] out_size;
  logic              out_overrun;

  logic    out_busy;
  logic    finish;
  status_t fin_status;
  logic    lookup_hit;

  assign req.ready = (state == S_IDLE);
  assign out_busy  = out_valid && !rsp.ready;
  assign finish    = (state == S_FINISH) && !out_busy;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (req.valid) state_next = S_SCAN;
      S_SCAN:   if (idx == LAST_IDX) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: if (!out_busy) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if ((state == S_CLEAR || state == S_SCAN) && idx != LAST_IDX) begin
        idx <= idx + 1'b1;
      end else begin
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op      <= op_t'(req.op);
      addr    <= req.addr;
      size    <= req.size;
      obj_id  <= req.obj_id;
      acc_end <= {1'b0, req.addr} + {{(ADDR_W-SIZE_W+1){1'b0}}, req.size};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx];
    rd_idx  <= idx;
  end

  assign scan_req.start  = req.valid && req.ready;
  assign scan_req.rd_vld = rd_vld;
  assign scan_req.addr   = addr;

  hrt_scan #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .req      (scan_req),
    .rd_data  (rd_data),
    .rd_idx   (rd_idx),
    .res      (scan_res),
    .match_idx(match_idx),
    .free_idx (free_idx)
  );

  assign lookup_hit = scan_res.best_hit && (scan_res.best_base != '0) &&
                      ({1'b0, addr} < scan_res.best_end);

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = '0;
    fin_status = ST_MISS;
    case (op)
      OP_ALLOC: begin
        if (scan_res.match_hit) begin
          fin_status = ST_DUP;
        end else if (!scan_res.free_hit) begin
          fin_status = ST_FULL;
        end else begin
          fin_status = ST_OK;
          mem_waddr  = free_idx;
          mem_wdata  = '{valid: 1'b1, ident: obj_id, len: size, base: addr};
          mem_we     = finish;
        end
      end
      OP_FREE: begin
        if (scan_res.match_hit) begin
          fin_status = ST_OK;
          mem_waddr  = match_idx;
          mem_we     = finish;
        end
      end
      OP_LOOKUP: begin
        if (lookup_hit) begin
          fin_status = ST_OK;
        end
      end
      default: fin_status = ST_MISS;
    endcase
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status  <= fin_status;
      out_id      <= '0;
      out_base    <= '0;
      out_size    <= '0;
      out_overrun <= 1'b0;
      if (op == OP_FREE && scan_res.match_hit) begin
        out_id   <= scan_res.match_ident;
        out_base <= addr;
        out_size <= scan_res.match_len;
      end else if (op == OP_LOOKUP && lookup_hit) begin
        out_id      <= scan_res.best_ident;
        out_base    <= scan_res.best_base;
        out_size    <= scan_res.best_len;
        out_overrun <= (acc_end > scan_res.best_end);
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found_id   = out_id;
  assign rsp.found_base = out_base;
  assign rsp.found_size = out_size;
  assign rsp.overrun    = out_overrun;

endmodule
`default_nettype wire

/* hdl/hrt_checker.sv */
// Port-level checks for the heap region tracker, attached by a bind.
// Depends on hrt_pkg and on the top level heap_region_tracker.
`default_nettype none
module hrt_checker import hrt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [1:0]        rsp_status,
  input wire logic [ID_W-1:0]   rsp_found_id,
  input wire logic [ADDR_W-1:0] rsp_found_base,
  input wire logic [SIZE_W-1:0] rsp_found_size,
  input wire logic              rsp_overrun
);

  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending <= pending + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      pending <= pending - 1'b1;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("Request accepted during the clearing pass.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("Request accepted while a transaction is in progress.");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> (pending != 2'd0))
    else $error("Response transaction without an outstanding request.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_id) && $stable(rsp_found_base) &&
      $stable(rsp_found_size) && $stable(rsp_overrun)))
    else $error("Stalled response changed.");

endmodule

bind heap_region_tracker hrt_checker u_hrt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_found_id  (rsp.found_id),
  .rsp_found_base(rsp.found_base),
  .rsp_found_size(rsp.found_size),
  .rsp_overrun   (rsp.overrun)
);
`default_nettype wire
